### design/tss_pkg.sv
// Shared types and constants for the three-stack shared-array block.
package tss_pkg;

   // Fixed width of the transaction value fields
   localparam int VALUE_WIDTH = 32;

   // Action codes
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // Stack select codes
   typedef enum logic [1:0] {
      STK_BOTTOM = 2'd0,
      STK_TOP    = 2'd1,
      STK_MIDDLE = 2'd2,
      STK_NONE   = 2'd3
   } stack_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_NO_STACK  = 2'd3
   } status_type;

   // Result selection for the response register
   typedef enum logic [1:0] {
      RES_PUSHED    = 2'd0,
      RES_OVERFLOW  = 2'd1,
      RES_UNDERFLOW = 2'd2,
      RES_NO_STACK  = 2'd3
   } res_code_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SHIFT,
      ST_DRAIN,
      ST_WRITE,
      ST_POP_WAIT,
      ST_DONE
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic         capture;
      logic         shift_up;
      logic         shift_down;
      logic         shift_step;
      logic         push_write;
      logic         pop_read;
      logic         res_set;
      res_code_type res_code;
      logic         res_pop;
      logic         rsp_load;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic      action;
      stack_type sel;
      logic      full;
      logic      bottom_meets;
      logic      upper_meets;
      logic      mid_empty;
      logic      empty;
      logic      shift_last;
   } sts_type;

endpackage

### design/three_stacks_shared_array.sv
// Three LIFO stacks in one shared memory of CAPACITY words. Stack 0 grows up from
// address 0, stack 1 grows down from the top address and stack 2 grows up from a base
// that starts at CAPACITY/3 and moves when another stack runs into it. Each request
// transaction is a push or pop naming one stack and yields exactly one response
// transaction with pop_value and status (0 ok, 1 overflow, 2underflow, 3 no such
// stack). A pop or a push that needs no move passes through decide, write or pop wait
// and done before the next acceptance; a push that must move the middle stack of n
// words (n is at most CAPACITY - 1) also passes through shift and drain, since the
// memory has one read and one write port and the move copies one word per cycle. A new
// request is taken while an earlier response still waits on rsp_stall.
module three_stacks_shared_array #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [1:0]         req_stack_select,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pop_value,
   output logic [1:0]         rsp_status
);

   tss_pkg::cmd_type cmd;
   tss_pkg::sts_type sts;
   logic [tss_pkg::VALUE_WIDTH-1:0] pop_value;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tss_datapath #(
      .CAPACITY   (CAPACITY),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_stack_select (req_stack_select),
      .req_push_value   (req_push_value),
      .rsp_pop_value    (pop_value),
      .rsp_status       (rsp_status)
   );

   assign rsp_pop_value = $signed(pop_value);

endmodule

### design/tss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/tss_ctrl.sv
// Controller state machine for the three-stack shared-array block.
module tss_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  tss_pkg::sts_type sts,
   output tss_pkg::cmd_type cmd
);

   tss_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tss_pkg::ST_IDLE: begin
            if (req_valid) state_in = tss_pkg::ST_DECIDE;
         end
         tss_pkg::ST_DECIDE: begin
            priority if (sts.sel == tss_pkg::STK_NONE) begin
               state_in = tss_pkg::ST_DONE;
            end else if (sts.action == tss_pkg::ACT_PUSH) begin
               priority if (sts.full) begin
                  state_in = tss_pkg::ST_DONE;
               end else if ((sts.sel == tss_pkg::STK_BOTTOM && sts.bottom_meets) ||
                            (sts.sel != tss_pkg::STK_BOTTOM && sts.upper_meets)) begin
                  state_in = sts.mid_empty ? tss_pkg::ST_WRITE : tss_pkg::ST_SHIFT;
               end else begin
                  state_in = tss_pkg::ST_WRITE;
               end
            end else begin
               state_in = sts.empty ? tss_pkg::ST_DONE : tss_pkg::ST_POP_WAIT;
            end
         end
         tss_pkg::ST_SHIFT: begin
            if (sts.shift_last) state_in = tss_pkg::ST_DRAIN;
         end
         tss_pkg::ST_DRAIN:    state_in = tss_pkg::ST_WRITE;
         tss_pkg::ST_WRITE:    state_in = tss_pkg::ST_DONE;
         tss_pkg::ST_POP_WAIT: state_in = tss_pkg::ST_DONE;
         tss_pkg::ST_DONE: begin
            if (slot_free) state_in = tss_pkg::ST_IDLE;
         end
         default: state_in = tss_pkg::ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd          = '0;
      cmd.res_code = tss_pkg::RES_PUSHED;
      unique case (state_ff)
         tss_pkg::ST_IDLE: begin
            cmd.capture = req_valid;
         end
         tss_pkg::ST_DECIDE: begin
            priority if (sts.sel == tss_pkg::STK_NONE) begin
               cmd.res_set  = 1'b1;
               cmd.res_code = tss_pkg::RES_NO_STACK;
            end else if (sts.action == tss_pkg::ACT_PUSH) begin
               priority if (sts.full) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = tss_pkg::RES_OVERFLOW;
               end else if (sts.sel == tss_pkg::STK_BOTTOM && sts.bottom_meets) begin
                  cmd.shift_up = 1'b1;
               end else if (sts.sel != tss_pkg::STK_BOTTOM && sts.upper_meets) begin
                  cmd.shift_down = 1'b1;
               end else begin
                  cmd.shift_up = 1'b0;
               end
            end else begin
               if (sts.empty) begin
                  cmd.res_set  = 1'b1;
                  cmd.res_code = tss_pkg::RES_UNDERFLOW;
               end else begin
                  cmd.pop_read = 1'b1;
               end
            end
         end
         tss_pkg::ST_SHIFT: begin
            cmd.shift_step = 1'b1;
         end
         tss_pkg::ST_DRAIN: begin
            cmd.shift_step = 1'b0;
         end
         tss_pkg::ST_WRITE: begin
            cmd.push_write = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_code   = tss_pkg::RES_PUSHED;
         end
         tss_pkg::ST_POP_WAIT: begin
            cmd.res_pop = 1'b1;
         end
         tss_pkg::ST_DONE: begin
            cmd.rsp_load = slot_free;
         end
         default: cmd = '0;
      endcase
   end

   // Hold the response valid until the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != tss_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### design/tss_datapath.sv
// Datapath: stack pointers, shift sequencer, shared memory and response registers.
module tss_datapath #(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tss_pkg::cmd_type                     cmd,
   output tss_pkg::sts_type                     sts,
   input  logic                                 req_action,
   input  logic [1:0]                           req_stack_select,
   input  logic [tss_pkg::VALUE_WIDTH-1:0]      req_push_value,
   output logic [tss_pkg::VALUE_WIDTH-1:0]      rsp_pop_value,
   output logic [1:0]                           rsp_status
);

   localparam int AW = $clog2(CAPACITY + 1);   // pointer width, holds 0..CAPACITY
   localparam int MW = $clog2(CAPACITY);       // memory address width
   localparam logic [AW-1:0] PTR_CAP  = AW'(CAPACITY);
   localparam logic [AW-1:0] PTR_MID  = AW'(CAPACITY / 3);
   localparam logic [AW-1:0] PTR_ONE  = AW'(1);
   localparam logic [WORD_WIDTH-1:0] SENT_W = WORD_WIDTH'(1) << (WORD_WIDTH - 1);
   localparam logic [tss_pkg::VALUE_WIDTH-1:0] SENTINEL = tss_pkg::VALUE_WIDTH'(SENT_W);

   // Latched transaction
   logic                            item_action_ff;
   tss_pkg::stack_type              item_sel_ff;
   logic [tss_pkg::VALUE_WIDTH-1:0] item_value_ff;

   // Pointers, all biased to 0..CAPACITY:
   // bot = count of bottom stack, upp = upper top, mb = middle base, mt = middle top + 1
   logic [AW-1:0] bot_ff, bot_in;
   logic [AW-1:0] upp_ff, upp_in;
   logic [AW-1:0] mb_ff,  mb_in;
   logic [AW-1:0] mt_ff,  mt_in;

   // Shift sequencer
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] src_ff, src_in;
   logic          dir_up_ff, dir_up_in;
   logic          wr_pend_ff;
   logic [MW-1:0] wr_addr_ff;

   // Result and response registers
   logic [tss_pkg::VALUE_WIDTH-1:0] res_value_ff;
   tss_pkg::status_type             res_status_ff;
   logic [tss_pkg::VALUE_WIDTH-1:0] rsp_value_ff;
   tss_pkg::status_type             rsp_status_ff;

   // Memory ports
   logic                  ram_wr_en;
   logic [MW-1:0]         ram_wr_addr;
   logic [WORD_WIDTH-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [MW-1:0]         ram_rd_addr;
   logic [WORD_WIDTH-1:0] ram_rd_data;

   logic [AW-1:0] bot_dec, upp_dec, mt_dec;
   logic [MW-1:0] push_addr, pop_addr;

   assign bot_dec = bot_ff - PTR_ONE;
   assign upp_dec = upp_ff - PTR_ONE;
   assign mt_dec  = mt_ff - PTR_ONE;

   // Status toward the controller
   always_comb begin
      sts.action       = item_action_ff;
      sts.sel          = item_sel_ff;
      sts.bottom_meets = (mb_ff == bot_ff);
      sts.upper_meets  = (upp_ff == mt_ff);
      sts.full         = sts.bottom_meets && sts.upper_meets;
      sts.mid_empty    = (mb_ff == mt_ff);
      sts.shift_last   = (cnt_ff == PTR_ONE);
      unique case (item_sel_ff)
         tss_pkg::STK_BOTTOM: sts.empty = (bot_ff == '0);
         tss_pkg::STK_TOP:    sts.empty = (upp_ff == PTR_CAP);
         tss_pkg::STK_MIDDLE: sts.empty = (mb_ff == mt_ff);
         tss_pkg::STK_NONE:   sts.empty = 1'b0;
         default:             sts.empty = 1'b0;
      endcase
   end

   // Addresses of the selected stack's top
   always_comb begin
      unique case (item_sel_ff)
         tss_pkg::STK_BOTTOM: begin
            push_addr = bot_ff[MW-1:0];
            pop_addr  = bot_dec[MW-1:0];
         end
         tss_pkg::STK_TOP: begin
            push_addr = upp_dec[MW-1:0];
            pop_addr  = upp_ff[MW-1:0];
         end
         tss_pkg::STK_MIDDLE: begin
            push_addr = mt_ff[MW-1:0];
            pop_addr  = mt_dec[MW-1:0];
         end
         default: begin
            push_addr = '0;
            pop_addr  = '0;
         end
      endcase
   end

   // Pointer and shift sequencer updates
   always_comb begin
      bot_in    = bot_ff;
      upp_in    = upp_ff;
      mb_in     = mb_ff;
      mt_in     = mt_ff;
      cnt_in    = cnt_ff;
      src_in    = src_ff;
      dir_up_in = dir_up_ff;
      if (cmd.shift_up) begin
         // Middle block moves up: copy from its top down to its base
         mb_in     = mb_ff + PTR_ONE;
         mt_in     = mt_ff + PTR_ONE;
         cnt_in    = mt_ff - mb_ff;
         src_in    = mt_dec[MW-1:0];
         dir_up_in = 1'b1;
      end
      if (cmd.shift_down) begin
         // Middle block moves down: copy from its base up to its top
         mb_in     = mb_ff - PTR_ONE;
         mt_in     = mt_dec;
         cnt_in    = mt_ff - mb_ff;
         src_in    = mb_ff[MW-1:0];
         dir_up_in = 1'b0;
      end
      if (cmd.shift_step) begin
         cnt_in = cnt_ff - PTR_ONE;
         src_in = dir_up_ff ? src_ff - MW'(1) : src_ff + MW'(1);
      end
      if (cmd.push_write) begin
         unique case (item_sel_ff)
            tss_pkg::STK_BOTTOM: bot_in = bot_ff + PTR_ONE;
            tss_pkg::STK_TOP:    upp_in = upp_dec;
            tss_pkg::STK_MIDDLE: mt_in  = mt_ff + PTR_ONE;
            default:             bot_in = bot_ff;
         endcase
      end
      if (cmd.pop_read) begin
         unique case (item_sel_ff)
            tss_pkg::STK_BOTTOM: bot_in = bot_dec;
            tss_pkg::STK_TOP:    upp_in = upp_ff + PTR_ONE;
            tss_pkg::STK_MIDDLE: mt_in  = mt_dec;
            default:             bot_in = bot_ff;
         endcase
      end
   end

   // Memory port selection: shift copies own the write port while pending
   always_comb begin
      ram_rd_en   = cmd.shift_step || cmd.pop_read;
      ram_rd_addr = cmd.shift_step ? src_ff : pop_addr;
      ram_wr_en   = wr_pend_ff || cmd.push_write;
      ram_wr_addr = wr_pend_ff ? wr_addr_ff : push_addr;
      ram_wr_data = wr_pend_ff ? ram_rd_data : WORD_WIDTH'(item_value_ff);
   end

   tss_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bot_ff     <= '0;
         upp_ff     <= PTR_CAP;
         mb_ff      <= PTR_MID;
         mt_ff      <= PTR_MID;
         cnt_ff     <= '0;
         dir_up_ff  <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         bot_ff     <= bot_in;
         upp_ff     <= upp_in;
         mb_ff      <= mb_in;
         mt_ff      <= mt_in;
         cnt_ff     <= cnt_in;
         dir_up_ff  <= dir_up_in;
         wr_pend_ff <= cmd.shift_step;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      if (cmd.shift_step) begin
         wr_addr_ff <= dir_up_ff ? src_ff + MW'(1) : src_ff - MW'(1);
      end
      if (cmd.capture) begin
         item_action_ff <= req_action;
         item_sel_ff    <= tss_pkg::stack_type'(req_stack_select);
         item_value_ff  <= req_push_value;
      end
      if (cmd.res_set) begin
         unique case (cmd.res_code)
            tss_pkg::RES_PUSHED: begin
               res_value_ff  <= '0;
               res_status_ff <= tss_pkg::STATUS_OK;
            end
            tss_pkg::RES_OVERFLOW: begin
               res_value_ff  <= '0;
               res_status_ff <= tss_pkg::STATUS_OVERFLOW;
            end
            tss_pkg::RES_UNDERFLOW: begin
               res_value_ff  <= SENTINEL;
               res_status_ff <= tss_pkg::STATUS_UNDERFLOW;
            end
            tss_pkg::RES_NO_STACK: begin
               res_value_ff  <= SENTINEL;
               res_status_ff <= tss_pkg::STATUS_NO_STACK;
            end
            default: begin
               res_value_ff  <= '0;
               res_status_ff <= tss_pkg::STATUS_OK;
            end
         endcase
      end
      if (cmd.res_pop) begin
         res_value_ff  <= tss_pkg::VALUE_WIDTH'(ram_rd_data);
         res_status_ff <= tss_pkg::STATUS_OK;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= res_value_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_pop_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   // Stacks never cross: bottom top, middle base, middle top, upper top stay ordered
   a_ptr_order: assert property (@(posedge clock) disable iff (reset)
      (bot_ff <= mb_ff) && (mb_ff <= mt_ff) && (mt_ff <= upp_ff) && (upp_ff <= PTR_CAP))
      else $error("stack pointers out of order");

   // A pending shift copy and a push write never share the write port
   a_wr_port: assert property (@(posedge clock) disable iff (reset)
      !(wr_pend_ff && cmd.push_write))
      else $error("shift copy collides with push write");

   // A shift step only runs while words remain to be moved
   a_shift_cnt: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_step |-> (cnt_ff != '0))
      else $error("shift step with no words left");

   // A pop read is never issued on an empty stack
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_read |-> !sts.empty && (item_sel_ff != tss_pkg::STK_NONE))
      else $error("pop read of empty stack");

endmodule
